FILE: design/fwhc_pkg.sv
// Shared types, constants, the FNV-1a byte step and the word fold for the word hash combine unit.
`default_nettype none

package fwhc_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned NUM_BYTES = WORD_W / BYTE_W;

    localparam logic [WORD_W-1:0] FNV_BASIS = 64'hcbf29ce484222325;
    // The FNV-1a 64-bit prime is 2^40 + 0x1b3.
    localparam logic [WORD_W-1:0] FNV_PRIME_LO = 64'h00000000000001b3;
    localparam int unsigned FNV_PRIME_SHIFT = 40;
    localparam logic [WORD_W-1:0] MIX_CONST = 64'h9e3779b97f4a7c15;

    typedef struct packed {
        logic [WORD_W-1:0] fnv;
        logic              first;
        logic              last;
    } t_item;

    function automatic logic [WORD_W-1:0] fnv_step(
        input logic [WORD_W-1:0] h,
        input logic [BYTE_W-1:0] b
    );
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] lo;
        x = h ^ {{(WORD_W-BYTE_W){1'b0}}, b};
        lo = x * FNV_PRIME_LO;
        return lo + {x[WORD_W-FNV_PRIME_SHIFT-1:0], {FNV_PRIME_SHIFT{1'b0}}};
    endfunction

    function automatic logic [WORD_W-1:0] fold_word(
        input logic [WORD_W-1:0] h,
        input logic [WORD_W-1:0] f
    );
        return h ^ (MIX_CONST + (h << 6) + (h >> 2) + f);
    endfunction

endpackage

`default_nettype wire

FILE: design/fnv1a_word_hash_combine_unit.sv
// Top level of the FNV-1a word hash combine unit.
`default_nettype none

// Hashes records of 64-bit words, one word per transaction, and returns one 64-bit hash per
// record on the transaction that carries last. Each word is hashed with FNV-1a in an
// eight-stage pipeline, one byte per stage, and then folded into the running hash by a
// combinational combine loop in the back end, which sustains one word per cycle while the
// output is not stalled. The last word of a record enters the first pipeline stage on the
// accepting edge, passes on to the eighth, is written into the queue and is then folded
// into the output register, where the record's hash becomes valid. The queue
// of QUEUE_DEPTH entries lets the front end keep taking words while the output is stalled,
// until it fills. A word without first that follows reset or a finished record is folded
// into the value left behind, which is zero after reset.
module fnv1a_word_hash_combine_unit #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [fwhc_pkg::WORD_W-1:0] i_word,
    input  wire logic                        i_first,
    input  wire logic                        i_last,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [fwhc_pkg::WORD_W-1:0]      o_hash
);
    import fwhc_pkg::*;

    logic  push_valid;
    logic  push_ready;
    t_item push_item;
    logic  pop_valid;
    logic  pop_ready;
    t_item pop_item;

    fwhc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_word       (i_word),
        .i_first      (i_first),
        .i_last       (i_last),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_item  (push_item)
    );

    fwhc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_item  (push_item),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_item   (pop_item)
    );

    fwhc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pop_valid (pop_valid),
        .o_pop_ready (pop_ready),
        .i_pop_item  (pop_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_hash      (o_hash)
    );

endmodule

`default_nettype wire

FILE: design/fwhc_front.sv
// Front end: accepts words and hashes each one with FNV-1a in an eight-stage pipeline.
`default_nettype none

module fwhc_front (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    output logic                             o_ready,
    input  wire logic [fwhc_pkg::WORD_W-1:0] i_word,
    input  wire logic                        i_first,
    input  wire logic                        i_last,
    output logic                             o_push_valid,
    input  wire logic                        i_push_ready,
    output fwhc_pkg::t_item                  o_push_item
);
    import fwhc_pkg::*;

    logic [WORD_W-1:0]    r_h    [NUM_BYTES];
    logic [WORD_W-1:0]    r_word [NUM_BYTES];
    logic [NUM_BYTES-1:0] r_first;
    logic [NUM_BYTES-1:0] r_last;
    logic [NUM_BYTES-1:0] r_vld;
    logic                 advance;

    assign advance = !r_vld[NUM_BYTES-1] || i_push_ready;
    assign o_ready = advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (advance) begin
            r_vld <= {r_vld[NUM_BYTES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_h[0]     <= fnv_step(FNV_BASIS, i_word[BYTE_W-1:0]);
            r_word[0]  <= i_word;
            r_first[0] <= i_first;
            r_last[0]  <= i_last;
        end
    end

    for (genvar k = 1; k < NUM_BYTES; k++) begin : g_stage
        always_ff @(posedge i_clk) begin
            if (advance) begin
                r_h[k]     <= fnv_step(r_h[k-1], r_word[k-1][BYTE_W*k +: BYTE_W]);
                r_word[k]  <= r_word[k-1];
                r_first[k] <= r_first[k-1];
                r_last[k]  <= r_last[k-1];
            end
        end
    end

    assign o_push_valid      = r_vld[NUM_BYTES-1];
    assign o_push_item.fnv   = r_h[NUM_BYTES-1];
    assign o_push_item.first = r_first[NUM_BYTES-1];
    assign o_push_item.last  = r_last[NUM_BYTES-1];

endmodule

`default_nettype wire

FILE: design/fwhc_queue.sv
// Small FIFO that decouples the hashing front end from the combining back end.
`default_nettype none

module fwhc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push_valid,
    output logic                 o_push_ready,
    input  wire fwhc_pkg::t_item i_push_item,
    output logic                 o_pop_valid,
    input  wire logic            i_pop_ready,
    output fwhc_pkg::t_item      o_pop_item
);
    import fwhc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    t_item             r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [CNT_W-1:0]  r_count;
    logic              push;
    logic              pop;

    assign o_push_ready = (r_count != FULL_CNT);
    assign o_pop_valid  = (r_count != '0);
    assign push         = i_push_valid && o_push_ready;
    assign pop          = o_pop_valid && i_pop_ready;
    assign o_pop_item   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_push_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

FILE: design/fwhc_back.sv
// Back end: folds word hashes into the running hash and holds the finished record hash.
`default_nettype none

module fwhc_back (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_pop_valid,
    output logic                             o_pop_ready,
    input  wire fwhc_pkg::t_item             i_pop_item,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic [fwhc_pkg::WORD_W-1:0]      o_hash
);
    import fwhc_pkg::*;

    logic [WORD_W-1:0] r_hash;
    logic [WORD_W-1:0] n_hash;
    logic [WORD_W-1:0] r_out;
    logic              r_out_vld;
    logic              pop;

    assign o_pop_ready = !r_out_vld || i_ready;
    assign pop         = i_pop_valid && o_pop_ready;
    assign n_hash      = i_pop_item.first ? i_pop_item.fnv
                                          : fold_word(r_hash, i_pop_item.fnv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            if (pop) begin
                r_hash <= n_hash;
            end
            if (pop && i_pop_item.last) begin
                r_out_vld <= 1'b1;
            end else if (i_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && i_pop_item.last) begin
            r_out <= n_hash;
        end
    end

    assign o_valid = r_out_vld;
    assign o_hash  = r_out;

endmodule

`default_nettype wire
